// ----- hw/rtl/swtb_pkg.sv -----
// Package for the software timer bank: request function codes, slot modes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package swtb_pkg;

   localparam int unsigned FUNC_W = 2;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned MODE_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_SCHED_NSHOT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCHED_CONT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DESCHED     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK        = 2'd3;

   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NSHOT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONT  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_cmd;   // apply a schedule or deschedule request
      logic start_scan; // latch the tick time and read slot 0
      logic step;       // evaluate the current slot
      logic flush;      // deliver the final result of the tick
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic step_ok;    // the current slot can be retired this cycle
      logic last_slot;  // the scan pointer is at the final slot
      logic out_free;   // the result register can take a new transfer
   } dp_status_type;

endpackage

// ----- hw/rtl/software_timer_bank_top.sv -----
// Top level of the software timer bank: controller and datapath.
// Depends on swtb_pkg, swtb_ctrl and swtb_datapath.
//
//   Channel   Direction  Ports
//   req_*     in         valid/stall; func, slot, interval, shots, now_time
//   rsp_*     out        valid/stall; fired, fired_slot, finished, last
//
// A schedule or deschedule request is written into slot storage when it is accepted. A tick
// is accepted in ST_IDLE, which latches the tick time and reads slot 0; in ST_SCAN the shared
// compare unit steps through the slots, reading the next slot from storage while it evaluates
// the current one, and ST_FLUSH delivers the final result. Stall on rsp_ can hold both.
// Reset clears all slots to idle and the result register to empty.
module software_timer_bank_top #(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swtb_pkg::FUNC_W-1:0]   req_func,
   input  logic [swtb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [swtb_pkg::DATA_W-1:0]   req_interval,
   input  logic [swtb_pkg::DATA_W-1:0]   req_shots,
   input  logic [swtb_pkg::DATA_W-1:0]   req_now_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fired,
   output logic [swtb_pkg::SLOT_W-1:0]   rsp_fired_slot,
   output logic                          rsp_finished,
   output logic                          rsp_last
);

   swtb_pkg::dp_cmd_type    dp_cmd;
   swtb_pkg::dp_status_type dp_status;

   swtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   swtb_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_func       (req_func),
      .req_slot       (req_slot),
      .req_interval   (req_interval),
      .req_shots      (req_shots),
      .req_now_time   (req_now_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fired      (rsp_fired),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_finished   (rsp_finished),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- hw/rtl/swtb_ctrl.sv -----
// Controller state machine of the software timer bank.
// Depends on swtb_pkg for the state type, function codes and command/status structs.
module swtb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [swtb_pkg::FUNC_W-1:0]   req_func,
   output logic                          req_stall,
   output swtb_pkg::dp_cmd_type          dp_cmd,
   input  swtb_pkg::dp_status_type       dp_status
);

   swtb_pkg::state_type state_ff;
   swtb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swtb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swtb_pkg::ST_IDLE: begin
            if (req_valid && (req_func == swtb_pkg::FUNC_TICK)) begin
               state_in = swtb_pkg::ST_SCAN;
            end
         end
         swtb_pkg::ST_SCAN: begin
            if (dp_status.step_ok && dp_status.last_slot) begin
               state_in = swtb_pkg::ST_FLUSH;
            end
         end
         swtb_pkg::ST_FLUSH: begin
            if (dp_status.out_free) begin
               state_in = swtb_pkg::ST_IDLE;
            end
         end
         default: state_in = swtb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      dp_cmd    = '0;
      unique case (state_ff)
         swtb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_func == swtb_pkg::FUNC_TICK) begin
                  dp_cmd.start_scan = 1'b1;
               end else begin
                  dp_cmd.load_cmd = 1'b1;
               end
            end
         end
         swtb_pkg::ST_SCAN: begin
            dp_cmd.step = 1'b1;
         end
         swtb_pkg::ST_FLUSH: begin
            dp_cmd.flush = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- hw/rtl/swtb_datapath.sv -----
// Datapath of the software timer bank: slot storage, expiry compare,
// one pending result and the result register.
// Depends on swtb_pkg for field widths, codes and command/status structs.
module swtb_datapath #(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swtb_pkg::dp_cmd_type          dp_cmd,
   output swtb_pkg::dp_status_type       dp_status,
   input  logic [swtb_pkg::FUNC_W-1:0]   req_func,
   input  logic [swtb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [swtb_pkg::DATA_W-1:0]   req_interval,
   input  logic [swtb_pkg::DATA_W-1:0]   req_shots,
   input  logic [swtb_pkg::DATA_W-1:0]   req_now_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fired,
   output logic [swtb_pkg::SLOT_W-1:0]   rsp_fired_slot,
   output logic                          rsp_finished,
   output logic                          rsp_last
);

   localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   // Slot storage. Mode is in resettable flops; the rest is plain memory.
   logic [swtb_pkg::MODE_W-1:0] mode_ff [NUM_SLOTS];
   logic [swtb_pkg::DATA_W-1:0] interval_mem [NUM_SLOTS];
   logic [swtb_pkg::DATA_W-1:0] start_mem [NUM_SLOTS];
   logic [swtb_pkg::DATA_W-1:0] remain_mem [NUM_SLOTS];

   logic [swtb_pkg::DATA_W-1:0] interval_rd_ff;
   logic [swtb_pkg::DATA_W-1:0] start_rd_ff;
   logic [swtb_pkg::DATA_W-1:0] remain_rd_ff;

   logic [IDX_W-1:0]             ptr_ff;
   logic [swtb_pkg::DATA_W-1:0]  now_ff;

   logic                         pend_valid_ff;
   logic [swtb_pkg::SLOT_W-1:0]  pend_slot_ff;
   logic                         pend_fin_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_fired_ff;
   logic [swtb_pkg::SLOT_W-1:0]  rsp_fired_slot_ff;
   logic                         rsp_finished_ff;
   logic                         rsp_last_ff;

   logic                         slot_ok;
   logic [IDX_W-1:0]             cmd_idx;
   logic                         is_sched;
   logic [swtb_pkg::MODE_W-1:0]  cur_mode;
   logic [swtb_pkg::DATA_W-1:0]  elapsed;
   logic [swtb_pkg::DATA_W-1:0]  remain_dec;
   logic                         hit;
   logic                         is_cont;
   logic                         fin;
   logic                         out_free;
   logic                         step_ok;
   logic                         retire;
   logic                         last_slot;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic                         out_from_step;
   logic                         out_from_flush;

   assign slot_ok  = int'(req_slot) < NUM_SLOTS;
   assign cmd_idx  = IDX_W'(req_slot);
   assign is_sched = (req_func == swtb_pkg::FUNC_SCHED_NSHOT) ||
                     (req_func == swtb_pkg::FUNC_SCHED_CONT);

   // The tick compare: wrapping elapsed time against the stored interval.
   assign cur_mode   = mode_ff[ptr_ff];
   assign elapsed    = now_ff - start_rd_ff;
   assign remain_dec = remain_rd_ff - 1'b1;
   assign hit        = (cur_mode != swtb_pkg::MODE_IDLE) && (elapsed >= interval_rd_ff);
   assign is_cont    = (cur_mode == swtb_pkg::MODE_CONT);
   assign fin        = !is_cont && (remain_dec == '0);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = (ptr_ff == LAST_IDX);

   // A hit pushes the older pending result out, which needs a free result register.
   assign step_ok = !(hit && pend_valid_ff && !out_free);
   assign retire  = dp_cmd.step && step_ok;

   assign rd_en   = dp_cmd.start_scan || (retire && !last_slot);
   assign rd_addr = dp_cmd.start_scan ? '0 : ptr_ff + 1'b1;

   assign out_from_step  = retire && hit && pend_valid_ff;
   assign out_from_flush = dp_cmd.flush && out_free;

   assign dp_status.step_ok   = step_ok;
   assign dp_status.last_slot = last_slot;
   assign dp_status.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            mode_ff[i] <= swtb_pkg::MODE_IDLE;
         end
      end else if (dp_cmd.load_cmd && slot_ok) begin
         priority case (req_func)
            swtb_pkg::FUNC_SCHED_NSHOT: mode_ff[cmd_idx] <= swtb_pkg::MODE_NSHOT;
            swtb_pkg::FUNC_SCHED_CONT:  mode_ff[cmd_idx] <= swtb_pkg::MODE_CONT;
            default:                    mode_ff[cmd_idx] <= swtb_pkg::MODE_IDLE;
         endcase
      end else if (retire && hit && fin) begin
         mode_ff[ptr_ff] <= swtb_pkg::MODE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_cmd && slot_ok && is_sched) begin
         interval_mem[cmd_idx] <= req_interval;
         start_mem[cmd_idx]    <= req_now_time;
         if (req_func == swtb_pkg::FUNC_SCHED_NSHOT) begin
            remain_mem[cmd_idx] <= req_shots;
         end
      end else if (retire && hit) begin
         if (!fin) begin
            start_mem[ptr_ff] <= now_ff;
         end
         if (!is_cont) begin
            remain_mem[ptr_ff] <= remain_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         interval_rd_ff <= interval_mem[rd_addr];
         start_rd_ff    <= start_mem[rd_addr];
         remain_rd_ff   <= remain_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.start_scan) begin
         ptr_ff <= '0;
         now_ff <= req_now_time;
      end else if (retire && !last_slot) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (dp_cmd.start_scan) begin
         pend_valid_ff <= 1'b0;
      end else if (retire && hit) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (retire && hit) begin
         pend_slot_ff <= swtb_pkg::SLOT_W'(ptr_ff);
         pend_fin_ff  <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_from_step || out_from_flush) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // A result waits as pending until the next hit or the end of the scan,
   // which is when it is known whether it is the final one of the tick.
   always_ff @(posedge clock) begin
      if (out_from_step) begin
         rsp_fired_ff      <= 1'b1;
         rsp_fired_slot_ff <= pend_slot_ff;
         rsp_finished_ff   <= pend_fin_ff;
         rsp_last_ff       <= 1'b0;
      end else if (out_from_flush) begin
         rsp_fired_ff      <= pend_valid_ff;
         rsp_fired_slot_ff <= pend_valid_ff ? pend_slot_ff : '0;
         rsp_finished_ff   <= pend_valid_ff && pend_fin_ff;
         rsp_last_ff       <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_fired_slot = rsp_fired_slot_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
